FILE: hdl/gppe_pkg.sv
package gppe_pkg;

    // Grid defaults
    localparam int GRID_X_DEF = 64;
    localparam int GRID_Y_DEF = 64;
    localparam int GRID_Z_DEF = 64;

    // Field widths
    localparam int KIND_W  = 3;
    localparam int POS_W   = 6;
    localparam int CNT_W   = 16;
    localparam int MASK_W  = 6;
    localparam int CFG_W   = 32;
    localparam int CIDX_W  = 3;
    localparam int WGT_W   = 63;
    localparam int IDX_W   = 23;
    localparam int PROD_W  = 48;
    localparam int RX_W    = 5;
    localparam int IN_DATA_W  = 120;
    localparam int OUT_DATA_W = 88;

    localparam logic [WGT_W-1:0] WGT_MAX = {WGT_W{1'b1}};

    // Job queue
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = 1;

    // Request kinds
    localparam logic [KIND_W-1:0] KIND_INIT = 3'd0;
    localparam logic [KIND_W-1:0] KIND_ALL  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_ADP  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_ATP  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_E    = 3'd4;

    // Configuration register indexes
    localparam logic [CIDX_W-1:0] CFG_RATE_ADP  = 3'd0;
    localparam logic [CIDX_W-1:0] CFG_RATE_MEM  = 3'd1;
    localparam logic [CIDX_W-1:0] CFG_RATE_COOP = 3'd2;
    localparam logic [CIDX_W-1:0] CFG_RATE_EB   = 3'd3;
    localparam logic [CIDX_W-1:0] CFG_RATE_DER  = 3'd4;
    localparam logic [CIDX_W-1:0] CFG_DIFF      = 3'd5;
    localparam logic [CIDX_W-1:0] CFG_INV_VOL   = 3'd6;

    // Reaction numbers
    localparam logic [RX_W-1:0] RX_ADP_ATP  = 5'd0;
    localparam logic [RX_W-1:0] RX_DE_REL   = 5'd1;
    localparam logic [RX_W-1:0] RX_ATP_D    = 5'd2;
    localparam logic [RX_W-1:0] RX_E_D      = 5'd3;
    localparam logic [RX_W-1:0] RX_DIFF_ADP = 5'd4;
    localparam logic [RX_W-1:0] RX_DIFF_ATP = 5'd10;
    localparam logic [RX_W-1:0] RX_DIFF_E   = 5'd16;

    typedef struct packed {
        logic [CFG_W-1:0] rate_adp;
        logic [CFG_W-1:0] rate_mem;
        logic [CFG_W-1:0] rate_coop;
        logic [CFG_W-1:0] rate_eb;
        logic [CFG_W-1:0] rate_der;
        logic [CFG_W-1:0] diff;
        logic [CFG_W-1:0] inv_vol;
    } cfg_t;

    typedef struct packed {
        logic [KIND_W-1:0] req_type;
        logic [POS_W-1:0]  pos_x;
        logic [POS_W-1:0]  pos_y;
        logic [POS_W-1:0]  pos_z;
        logic [CNT_W-1:0]  count_adp;
        logic [CNT_W-1:0]  count_atp;
        logic [CNT_W-1:0]  count_e;
        logic [CNT_W-1:0]  count_d;
        logic [CNT_W-1:0]  count_de;
        logic [CNT_W-1:0]  membrane_amount;
        logic [MASK_W-1:0] neighbor_inside;
    } item_t;

    // One classified point, ready for emission
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              mem_nz;
        logic [MASK_W-1:0] mask;
        logic [IDX_W-1:0]  cell_idx;
        logic [PROD_W-1:0] p_adp;
        logic [PROD_W-1:0] p_de;
        logic [PROD_W-1:0] d_adp;
        logic [PROD_W-1:0] d_atp;
        logic [PROD_W-1:0] d_e;
        logic [WGT_W-1:0]  w_atpd;
        logic [WGT_W-1:0]  w_ed;
    } job_t;

endpackage

FILE: hdl/gppe_front.sv
module gppe_front
    import gppe_pkg::*;
#(
    parameter int GRID_Y = GRID_Y_DEF,
    parameter int GRID_Z = GRID_Z_DEF
) (
    input  logic  aclk,
    input  logic  aresetn,
    input  cfg_t  cfg,
    input  logic  in_valid,
    output logic  in_ready,
    input  item_t in_item,
    output logic  push,
    output job_t  push_job,
    input  logic  q_full
);

    // Schedule of the shared multiplier: each step issues one product and writes back the product of the step before
    localparam logic [4:0] S_ADP_RX = 5'd0;
    localparam logic [4:0] S_DE_REL = 5'd1;
    localparam logic [4:0] S_D_ADP  = 5'd2;
    localparam logic [4:0] S_D_ATP  = 5'd3;
    localparam logic [4:0] S_D_E    = 5'd4;
    localparam logic [4:0] S_MEM    = 5'd5;
    localparam logic [4:0] S_COOP   = 5'd6;
    localparam logic [4:0] S_T      = 5'd7;
    localparam logic [4:0] S_U      = 5'd8;
    localparam logic [4:0] S_ST00   = 5'd9;
    localparam logic [4:0] S_V0     = 5'd10;
    localparam logic [4:0] S_ST01   = 5'd11;
    localparam logic [4:0] S_V1     = 5'd12;
    localparam logic [4:0] S_ST10   = 5'd13;
    localparam logic [4:0] S_ST11   = 5'd14;
    localparam logic [4:0] S_ED0    = 5'd15;
    localparam logic [4:0] S_ED1    = 5'd16;
    localparam logic [4:0] S_WB_END = 5'd17;
    localparam logic [4:0] S_PUSH   = 5'd18;

    logic              in_valid_reg;
    item_t             in_reg;
    logic              busy_reg;
    logic [4:0]        step_reg;
    item_t             work_reg;
    logic [IDX_W-1:0]  cell_reg;
    logic [63:0]       prod_reg;
    logic [PROD_W-1:0] p_adp_reg, p_de_reg, d_adp_reg, d_atp_reg, d_e_reg;
    logic [PROD_W-1:0] a_reg, t_reg, u_reg;
    logic [57:0]       s_reg;
    logic [63:0]       v_reg;
    logic [105:0]      acc_st_reg;
    logic [95:0]       acc_ed_reg;
    logic [31:0]       op_a, op_b;
    logic [16:0]       sum_dde;
    logic [IDX_W-1:0]  cell_next;
    logic              done_push;
    logic              start;

    assign in_ready  = !in_valid_reg;
    assign done_push = busy_reg && (step_reg == S_PUSH) && !q_full;
    assign start     = in_valid_reg && (!busy_reg || done_push);
    assign push      = done_push;
    assign sum_dde   = {1'b0, work_reg.count_d} + {1'b0, work_reg.count_de};

    // Flat cell index, modulo the index width
    assign cell_next = (IDX_W'(in_reg.pos_x) * IDX_W'(GRID_Y) + IDX_W'(in_reg.pos_y))
                       * IDX_W'(GRID_Z) + IDX_W'(in_reg.pos_z);

    // Hold one incoming transaction while the sequencer works
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (in_valid && in_ready) begin
            in_valid_reg <= 1'b1;
        end else if (start) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            in_reg <= in_item;
        end
    end

    // Step the sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            step_reg <= S_ADP_RX;
        end else if (start) begin
            busy_reg <= 1'b1;
            step_reg <= S_ADP_RX;
        end else if (done_push) begin
            busy_reg <= 1'b0;
        end else if (busy_reg && step_reg != S_PUSH) begin
            step_reg <= step_reg + 5'd1;
        end
    end

    // Select multiplier operands
    always_comb begin
        op_a = '0;
        op_b = '0;
        case (step_reg)
            S_ADP_RX: begin op_a = cfg.rate_adp;  op_b = 32'(work_reg.count_adp); end
            S_DE_REL: begin op_a = cfg.rate_der;  op_b = 32'(work_reg.count_de); end
            S_D_ADP:  begin op_a = cfg.diff;      op_b = 32'(work_reg.count_adp); end
            S_D_ATP:  begin op_a = cfg.diff;      op_b = 32'(work_reg.count_atp); end
            S_D_E:    begin op_a = cfg.diff;      op_b = 32'(work_reg.count_e); end
            S_MEM:    begin op_a = cfg.rate_mem;  op_b = 32'(work_reg.membrane_amount); end
            S_COOP:   begin op_a = cfg.rate_coop; op_b = 32'(sum_dde); end
            S_T:      begin op_a = cfg.inv_vol;   op_b = 32'(work_reg.count_atp); end
            S_U:      begin op_a = cfg.rate_eb;   op_b = 32'(work_reg.count_d); end
            S_ST00:   begin op_a = s_reg[31:0];   op_b = t_reg[31:0]; end
            S_V0:     begin op_a = u_reg[31:0];   op_b = 32'(work_reg.count_e); end
            S_ST01:   begin op_a = s_reg[31:0];   op_b = 32'(t_reg[47:32]); end
            S_V1:     begin op_a = 32'(u_reg[47:32]); op_b = 32'(work_reg.count_e); end
            S_ST10:   begin op_a = 32'(s_reg[57:32]); op_b = t_reg[31:0]; end
            S_ST11:   begin op_a = 32'(s_reg[57:32]); op_b = 32'(t_reg[47:32]); end
            S_ED0:    begin op_a = v_reg[31:0];   op_b = cfg.inv_vol; end
            S_ED1:    begin op_a = v_reg[63:32];  op_b = cfg.inv_vol; end
            default:  begin op_a = '0;            op_b = '0; end
        endcase
    end

    // Multiply, then write back the previous step's product
    always_ff @(posedge aclk) begin
        prod_reg <= op_a * op_b;
        if (start) begin
            work_reg <= in_reg;
            cell_reg <= cell_next;
        end
        if (busy_reg) begin
            case (step_reg)
                S_DE_REL: p_adp_reg  <= prod_reg[PROD_W-1:0];
                S_D_ADP:  p_de_reg   <= prod_reg[PROD_W-1:0];
                S_D_ATP:  d_adp_reg  <= prod_reg[PROD_W-1:0];
                S_D_E:    d_atp_reg  <= prod_reg[PROD_W-1:0];
                S_MEM:    d_e_reg    <= prod_reg[PROD_W-1:0];
                S_COOP:   a_reg      <= prod_reg[PROD_W-1:0];
                S_T:      s_reg      <= 58'(a_reg) + 58'({prod_reg[48:0], 8'h00});
                S_U:      t_reg      <= prod_reg[PROD_W-1:0];
                S_ST00:   u_reg      <= prod_reg[PROD_W-1:0];
                S_V0:     acc_st_reg <= 106'(prod_reg);
                S_ST01:   v_reg      <= prod_reg;
                S_V1:     acc_st_reg <= acc_st_reg + 106'({prod_reg, 32'h0});
                S_ST10:   v_reg      <= v_reg + {prod_reg[31:0], 32'h0};
                S_ST11:   acc_st_reg <= acc_st_reg + 106'({prod_reg, 32'h0});
                S_ED0:    acc_st_reg <= acc_st_reg + 106'({prod_reg, 64'h0});
                S_ED1:    acc_ed_reg <= 96'(prod_reg);
                S_WB_END: acc_ed_reg <= acc_ed_reg + 96'({prod_reg, 32'h0});
                default: ;
            endcase
        end
    end

    // Assemble the job, saturating the two long products
    always_comb begin
        push_job.kind     = work_reg.req_type;
        push_job.mem_nz   = (work_reg.membrane_amount != '0);
        push_job.mask     = work_reg.neighbor_inside;
        push_job.cell_idx = cell_reg;
        push_job.p_adp    = p_adp_reg;
        push_job.p_de     = p_de_reg;
        push_job.d_adp    = d_adp_reg;
        push_job.d_atp    = d_atp_reg;
        push_job.d_e      = d_e_reg;
        push_job.w_atpd   = (acc_st_reg[105:79] != '0) ? WGT_MAX : acc_st_reg[78:16];
        push_job.w_ed     = (acc_ed_reg[95:71] != '0) ? WGT_MAX : acc_ed_reg[70:8];
    end

endmodule

FILE: hdl/gppe_queue.sv
module gppe_queue
    import gppe_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  job_t push_job,
    output logic full,
    input  logic pop,
    output logic head_valid,
    output job_t head_job
);

    job_t               slots_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg;
    logic [Q_PTR_W-1:0] rd_ptr_reg;
    logic [Q_PTR_W:0]   count_reg;

    assign full       = (count_reg == (Q_PTR_W+1)'(Q_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_job   = slots_reg[rd_ptr_reg];

    // Store pushed jobs
    always_ff @(posedge aclk) begin
        if (push) begin
            slots_reg[wr_ptr_reg] <= push_job;
        end
    end

    // Advance pointers and count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

FILE: hdl/gppe_back.sv
module gppe_back
    import gppe_pkg::*;
#(
    parameter int GRID_X = GRID_X_DEF,
    parameter int GRID_Y = GRID_Y_DEF,
    parameter int GRID_Z = GRID_Z_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  head_valid,
    input  job_t                  head_job,
    output logic                  pop,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic                  m_tlast
);

    localparam logic [IDX_W-1:0] CELLS_LO = IDX_W'(GRID_X * GRID_Y * GRID_Z);

    localparam logic [2:0] ST_RX0   = 3'd0;
    localparam logic [2:0] ST_ATPD  = 3'd1;
    localparam logic [2:0] ST_ED    = 3'd2;
    localparam logic [2:0] ST_DEREL = 3'd3;
    localparam logic [2:0] ST_DIFF  = 3'd4;

    localparam logic [1:0] SP_ADP = 2'd0;
    localparam logic [1:0] SP_ATP = 2'd1;
    localparam logic [1:0] SP_E   = 2'd2;

    logic [2:0]        stage_reg, stage_next;
    logic [2:0]        dir_reg, dir_next;
    logic [1:0]        sp_reg, sp_next;
    logic              m_tvalid_reg;
    logic [WGT_W-1:0]  m_weight_reg;
    logic [IDX_W-1:0]  m_index_reg;
    logic              m_tlast_reg;

    logic              emit;
    logic              has_mem;
    logic [1:0]        nsp;
    logic              has_diff;
    logic [MASK_W-1:0] above;
    logic              has_above;
    logic [2:0]        first_dir, above_dir;
    logic [1:0]        species;
    logic [WGT_W-1:0]  cur_weight;
    logic [RX_W-1:0]   cur_rx;
    logic              last;

    function automatic logic [2:0] lowest_set(input logic [MASK_W-1:0] m);
        logic [2:0] r;
        r = '0;
        for (int i = MASK_W - 1; i >= 0; i--) begin
            if (m[i]) begin
                r = 3'(i);
            end
        end
        return r;
    endfunction

    assign emit = head_valid && (!m_tvalid_reg || m_tready);
    assign pop  = emit && last;

    // Classify the head job
    always_comb begin
        has_mem = head_job.mem_nz || (head_job.kind == KIND_INIT);
        case (head_job.kind)
            KIND_INIT, KIND_ALL:       nsp = 2'd3;
            KIND_ADP, KIND_ATP, KIND_E: nsp = 2'd1;
            default:                   nsp = 2'd0;
        endcase
        has_diff  = (head_job.mask != '0) && (nsp != 2'd0);
        first_dir = lowest_set(head_job.mask);
        for (int i = 0; i < MASK_W; i++) begin
            above[i] = head_job.mask[i] && (3'(i) > dir_reg);
        end
        has_above = (above != '0);
        above_dir = lowest_set(above);
    end

    // Pick species for the current diffusion slot
    always_comb begin
        case (head_job.kind)
            KIND_INIT: species = (sp_reg == 2'd0) ? SP_ATP :
                                 (sp_reg == 2'd1) ? SP_ADP : SP_E;
            KIND_ALL:  species = (sp_reg == 2'd0) ? SP_ADP :
                                 (sp_reg == 2'd1) ? SP_ATP : SP_E;
            KIND_ADP:  species = SP_ADP;
            KIND_ATP:  species = SP_ATP;
            default:   species = SP_E;
        endcase
    end

    // Current result
    always_comb begin
        cur_weight = '0;
        cur_rx     = RX_ADP_ATP;
        case (stage_reg)
            ST_RX0: begin
                cur_weight = WGT_W'({head_job.p_adp, 8'h00});
                cur_rx     = RX_ADP_ATP;
            end
            ST_ATPD: begin
                cur_weight = head_job.mem_nz ? head_job.w_atpd : '0;
                cur_rx     = RX_ATP_D;
            end
            ST_ED: begin
                cur_weight = head_job.mem_nz ? head_job.w_ed : '0;
                cur_rx     = RX_E_D;
            end
            ST_DEREL: begin
                cur_weight = head_job.mem_nz ? WGT_W'({head_job.p_de, 8'h00}) : '0;
                cur_rx     = RX_DE_REL;
            end
            ST_DIFF: begin
                case (species)
                    SP_ADP: begin
                        cur_weight = WGT_W'({head_job.d_adp, 8'h00});
                        cur_rx     = RX_DIFF_ADP + RX_W'(dir_reg);
                    end
                    SP_ATP: begin
                        cur_weight = WGT_W'({head_job.d_atp, 8'h00});
                        cur_rx     = RX_DIFF_ATP + RX_W'(dir_reg);
                    end
                    default: begin
                        cur_weight = WGT_W'({head_job.d_e, 8'h00});
                        cur_rx     = RX_DIFF_E + RX_W'(dir_reg);
                    end
                endcase
            end
            default: begin
                cur_weight = '0;
                cur_rx     = RX_ADP_ATP;
            end
        endcase
    end

    // Next position in the emission order
    always_comb begin
        stage_next = ST_RX0;
        dir_next   = first_dir;
        sp_next    = '0;
        last       = 1'b0;
        case (stage_reg)
            ST_RX0: begin
                if (has_mem) begin
                    stage_next = ST_ATPD;
                end else if (has_diff) begin
                    stage_next = ST_DIFF;
                end else begin
                    last = 1'b1;
                end
            end
            ST_ATPD:  stage_next = ST_ED;
            ST_ED:    stage_next = ST_DEREL;
            ST_DEREL: begin
                if (has_diff) begin
                    stage_next = ST_DIFF;
                end else begin
                    last = 1'b1;
                end
            end
            ST_DIFF: begin
                if (sp_reg != nsp - 2'd1) begin
                    stage_next = ST_DIFF;
                    dir_next   = dir_reg;
                    sp_next    = sp_reg + 2'd1;
                end else if (has_above) begin
                    stage_next = ST_DIFF;
                    dir_next   = above_dir;
                end else begin
                    last = 1'b1;
                end
            end
            default: last = 1'b1;
        endcase
    end

    // Advance the position on each emitted transaction
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_reg <= ST_RX0;
            dir_reg   <= '0;
            sp_reg    <= '0;
        end else if (emit) begin
            stage_reg <= last ? ST_RX0 : stage_next;
            dir_reg   <= dir_next;
            sp_reg    <= sp_next;
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (emit) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            m_weight_reg <= cur_weight;
            m_index_reg  <= IDX_W'(IDX_W'(cur_rx) * CELLS_LO) + head_job.cell_idx;
            m_tlast_reg  <= last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {2'b00, m_index_reg, m_weight_reg};
    assign m_tlast  = m_tlast_reg;

endmodule

FILE: hdl/grid_point_propensity_emitter.sv
// Channel  | Dir | Transaction                 | Payload
// s_*      | in  | one lattice point           | tdata fields, tuser = req_type
// m_*      | out | one (weight, index) result  | tdata fields, tlast = last_result
// cfg_*    | in  | one register write          | cfg_index, cfg_data
//
// The front runs each point on its one shared 32x32 multiplier (17 products);
// the back emits 1 to 22 results per point, one per cycle while not stalled.
// Reset (aresetn low, synchronous) clears the configuration registers to zero
// and empties the queue and output stage.
// A two-job queue parts front and back; m_tready low holds the output register.
module grid_point_propensity_emitter
    import gppe_pkg::*;
#(
    parameter int GRID_X = GRID_X_DEF,
    parameter int GRID_Y = GRID_Y_DEF,
    parameter int GRID_Z = GRID_Z_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // pos_x, pos_y, pos_z, count_adp, count_atp, count_e, count_d, count_de,
    // membrane_amount, neighbor_inside
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // req_type
    input  logic [KIND_W-1:0]     s_tuser,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // weight, reaction_index, zero padding
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic                  m_tlast,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CIDX_W-1:0]     cfg_index,
    input  logic [CFG_W-1:0]      cfg_data
);

    cfg_t  cfg_reg;
    item_t in_item;
    logic  push, q_full, pop, head_valid;
    job_t  push_job, head_job;

    assign cfg_ready = 1'b1;

    // Write configuration registers; drop writes past the list
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_RATE_ADP:  cfg_reg.rate_adp  <= cfg_data;
                CFG_RATE_MEM:  cfg_reg.rate_mem  <= cfg_data;
                CFG_RATE_COOP: cfg_reg.rate_coop <= cfg_data;
                CFG_RATE_EB:   cfg_reg.rate_eb   <= cfg_data;
                CFG_RATE_DER:  cfg_reg.rate_der  <= cfg_data;
                CFG_DIFF:      cfg_reg.diff      <= cfg_data;
                CFG_INV_VOL:   cfg_reg.inv_vol   <= cfg_data;
                default: ;
            endcase
        end
    end

    // Unpack the input transaction
    always_comb begin
        in_item.req_type        = s_tuser;
        in_item.pos_x           = s_tdata[5:0];
        in_item.pos_y           = s_tdata[11:6];
        in_item.pos_z           = s_tdata[17:12];
        in_item.count_adp       = s_tdata[33:18];
        in_item.count_atp       = s_tdata[49:34];
        in_item.count_e         = s_tdata[65:50];
        in_item.count_d         = s_tdata[81:66];
        in_item.count_de        = s_tdata[97:82];
        in_item.membrane_amount = s_tdata[113:98];
        in_item.neighbor_inside = s_tdata[119:114];
    end

    gppe_front #(
        .GRID_Y (GRID_Y),
        .GRID_Z (GRID_Z)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_item  (in_item),
        .push     (push),
        .push_job (push_job),
        .q_full   (q_full)
    );

    gppe_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_job   (push_job),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_job   (head_job)
    );

    gppe_back #(
        .GRID_X (GRID_X),
        .GRID_Y (GRID_Y),
        .GRID_Z (GRID_Z)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head_job   (head_job),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

endmodule

FILE: sim/grid_point_propensity_emitter_tb.sv
`timescale 1ns / 100ps

module grid_point_propensity_emitter_tb;
    import gppe_pkg::*;

    // Grid size of the instance, cell count per reaction block
    localparam int GRID_X = GRID_X_DEF;
    localparam int GRID_Y = GRID_Y_DEF;
    localparam int GRID_Z = GRID_Z_DEF;
    localparam int unsigned CELLS = GRID_X * GRID_Y * GRID_Z;

    // Request kinds past the package list: reactions only, and two unused codes
    localparam logic [KIND_W-1:0] KIND_RXN      = 3'd5;
    localparam logic [KIND_W-1:0] KIND_SPARE_LO = 3'd6;
    localparam logic [KIND_W-1:0] KIND_SPARE_HI = 3'd7;

    // Register index with no register behind it
    localparam logic [CIDX_W-1:0] CFG_UNUSED = 3'd7;

    localparam int CFG_SETTLE   = 24;
    localparam int TAIL_CYCLES  = 40;
    localparam int STALL_LIMIT  = 4000;
    localparam int RAND_PHASES  = 6;
    localparam int RAND_PER_PH  = 68;

    typedef struct packed {
        logic [WGT_W-1:0] weight;
        logic [IDX_W-1:0] rindex;
        logic             last_flag;
    } propensity_t;

    typedef struct packed {
        logic [CIDX_W-1:0] idx;
        logic [CFG_W-1:0]  val;
    } reg_write_t;

    logic                  aclk;
    logic                  aresetn   = 1'b0;
    logic [IN_DATA_W-1:0]  s_tdata   = '0;
    logic [KIND_W-1:0]     s_tuser   = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tlast;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CIDX_W-1:0]     cfg_index = '0;
    logic [CFG_W-1:0]      cfg_data  = '0;

    item_t       pending_points[$];
    propensity_t pending_props[$];
    reg_write_t  reg_writes[$];
    cfg_t        rate_regs = '0;
    item_t       cur_point;
    int          gap_left = 0;
    int          stall_left = 0;
    int          stall_draw;
    int          quiet_cycles = 0;
    int          err_cnt = 0;
    bit          send_steady = 1'b0;
    bit          recv_steady = 1'b0;

    grid_point_propensity_emitter u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Propensity predictor
    // ------------------------------------------------------------------

    // Clamp an exact product to unsigned Q39.24
    function automatic logic [WGT_W-1:0] sat_q40(input logic [127:0] v);
        return (v > {65'd0, WGT_MAX}) ? WGT_MAX : v[WGT_W-1:0];
    endfunction

    function automatic propensity_t rate_item(input logic [WGT_W-1:0] w,
                                              input int unsigned rx,
                                              input int unsigned pt_cell);
        propensity_t pr;
        pr.weight    = w;
        pr.rindex    = IDX_W'(rx * CELLS + pt_cell);
        pr.last_flag = 1'b0;
        return pr;
    endfunction

    task automatic predict_propensities(input item_t p);
        int unsigned      pt_cell;
        logic [WGT_W-1:0] w_adp, w_atp, w_e;
        logic [127:0]     bind_sum;
        propensity_t      batch[$];
        propensity_t      pr;
        int               i;
        pt_cell = (int'(p.pos_x) * GRID_Y + int'(p.pos_y)) * GRID_Z + int'(p.pos_z);
        w_adp = sat_q40((128'(rate_regs.diff) * 128'(p.count_adp)) << 8);
        w_atp = sat_q40((128'(rate_regs.diff) * 128'(p.count_atp)) << 8);
        w_e   = sat_q40((128'(rate_regs.diff) * 128'(p.count_e)) << 8);

        batch.push_back(rate_item(
            sat_q40((128'(rate_regs.rate_adp) * 128'(p.count_adp)) << 8), RX_ADP_ATP,
            pt_cell));

        // Membrane reactions: real weights with membrane, zeros only on init
        if (p.membrane_amount != '0) begin
            bind_sum = 128'(rate_regs.rate_mem) * 128'(p.membrane_amount)
                     + ((128'(rate_regs.rate_coop)
                         * (128'(p.count_d) + 128'(p.count_de))) << 8);
            batch.push_back(rate_item(
                sat_q40((bind_sum * (128'(p.count_atp) * 128'(rate_regs.inv_vol))) >> 16),
                RX_ATP_D, pt_cell));
            batch.push_back(rate_item(
                sat_q40((128'(rate_regs.rate_eb) * 128'(p.count_d) * 128'(p.count_e)
                         * 128'(rate_regs.inv_vol)) >> 8),
                RX_E_D, pt_cell));
            batch.push_back(rate_item(
                sat_q40((128'(rate_regs.rate_der) * 128'(p.count_de)) << 8),
                RX_DE_REL, pt_cell));
        end else if (p.req_type == KIND_INIT) begin
            batch.push_back(rate_item('0, RX_ATP_D, pt_cell));
            batch.push_back(rate_item('0, RX_E_D, pt_cell));
            batch.push_back(rate_item('0, RX_DE_REL, pt_cell));
        end

        // Diffusion per inside neighbor, species order set by the request
        for (i = 0; i < MASK_W; i++) begin
            if (p.neighbor_inside[i]) begin
                case (p.req_type)
                    KIND_INIT: begin
                        batch.push_back(rate_item(w_atp, RX_DIFF_ATP + i, pt_cell));
                        batch.push_back(rate_item(w_adp, RX_DIFF_ADP + i, pt_cell));
                        batch.push_back(rate_item(w_e, RX_DIFF_E + i, pt_cell));
                    end
                    KIND_ALL: begin
                        batch.push_back(rate_item(w_adp, RX_DIFF_ADP + i, pt_cell));
                        batch.push_back(rate_item(w_atp, RX_DIFF_ATP + i, pt_cell));
                        batch.push_back(rate_item(w_e, RX_DIFF_E + i, pt_cell));
                    end
                    KIND_ADP: batch.push_back(rate_item(w_adp, RX_DIFF_ADP + i, pt_cell));
                    KIND_ATP: batch.push_back(rate_item(w_atp, RX_DIFF_ATP + i, pt_cell));
                    KIND_E:   batch.push_back(rate_item(w_e, RX_DIFF_E + i, pt_cell));
                    default: ;
                endcase
            end
        end

        foreach (batch[k]) begin
            pr = batch[k];
            pr.last_flag = (k == batch.size() - 1);
            pending_props.push_back(pr);
        end
    endtask

    // ------------------------------------------------------------------
    // Point driver: one transaction per queued point, a random gap (none when send_steady) after each
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            gap_left <= 0;
        end else begin
            if (s_tvalid && s_tready)
                predict_propensities(cur_point);
            if (!s_tvalid || s_tready) begin
                if (gap_left != 0) begin
                    gap_left <= gap_left - 1;
                    s_tvalid <= 1'b0;
                end else if (pending_points.size() != 0) begin
                    cur_point = pending_points.pop_front();
                    s_tdata  <= {cur_point.neighbor_inside, cur_point.membrane_amount,
                                 cur_point.count_de, cur_point.count_d, cur_point.count_e,
                                 cur_point.count_atp, cur_point.count_adp,
                                 cur_point.pos_z, cur_point.pos_y, cur_point.pos_x};
                    s_tuser  <= cur_point.req_type;
                    s_tvalid <= 1'b1;
                    gap_left <= send_steady ? 0 : $urandom_range(0, 8);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Register write driver; shadow copy follows each accepted write
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            cfg_valid <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_RATE_ADP:  rate_regs.rate_adp  = cfg_data;
                    CFG_RATE_MEM:  rate_regs.rate_mem  = cfg_data;
                    CFG_RATE_COOP: rate_regs.rate_coop = cfg_data;
                    CFG_RATE_EB:   rate_regs.rate_eb   = cfg_data;
                    CFG_RATE_DER:  rate_regs.rate_der  = cfg_data;
                    CFG_DIFF:      rate_regs.diff      = cfg_data;
                    CFG_INV_VOL:   rate_regs.inv_vol   = cfg_data;
                    default: ;
                endcase
            end
            if (!cfg_valid || cfg_ready) begin
                if (reg_writes.size() != 0) begin
                    cfg_index <= reg_writes[0].idx;
                    cfg_data  <= reg_writes[0].val;
                    cfg_valid <= 1'b1;
                    void'(reg_writes.pop_front());
                end else begin
                    cfg_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result monitor: compare each transaction with the oldest expectation
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("[%0t] MISMATCH %s: got %0h, expected %0h", $realtime, what, got, want);
        err_cnt++;
    endtask

    task automatic check_result();
        propensity_t want;
        if (pending_props.size() == 0) begin
            report_mismatch("result with nothing pending", 64'(m_tdata[WGT_W-1:0]), '0);
        end else begin
            want = pending_props.pop_front();
            if (m_tdata[WGT_W-1:0] !== want.weight)
                report_mismatch("weight", 64'(m_tdata[WGT_W-1:0]), 64'(want.weight));
            if (m_tdata[WGT_W +: IDX_W] !== want.rindex)
                report_mismatch("reaction_index", 64'(m_tdata[WGT_W +: IDX_W]),
                                64'(want.rindex));
            if (m_tlast !== want.last_flag)
                report_mismatch("tlast", 64'(m_tlast), 64'(want.last_flag));
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready   <= 1'b0;
            stall_left <= 0;
        end else if (m_tvalid && m_tready) begin
            check_result();
            stall_draw = recv_steady ? 0 : $urandom_range(0, 8);
            stall_left <= stall_draw;
            m_tready   <= (stall_draw == 0);
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= (stall_left == 1);
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Abort when no channel has moved a transaction for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
            || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == STALL_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    function automatic item_t make_pt(input logic [KIND_W-1:0] kind,
                                      input logic [POS_W-1:0] x, y, z,
                                      input logic [CNT_W-1:0] adp, atp, e, d, de, mem,
                                      input logic [MASK_W-1:0] mask);
        item_t p;
        p.req_type        = kind;
        p.pos_x           = x;
        p.pos_y           = y;
        p.pos_z           = z;
        p.count_adp       = adp;
        p.count_atp       = atp;
        p.count_e         = e;
        p.count_d         = d;
        p.count_de        = de;
        p.membrane_amount = mem;
        p.neighbor_inside = mask;
        return p;
    endfunction

    function automatic logic [CNT_W-1:0] rand_count();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2:       return CNT_W'($urandom_range(0, 15));
            default: return CNT_W'($urandom);
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] rand_rate();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2:       return $urandom_range(1, 32'h0001_0000);
            default: return $urandom;
        endcase
    endfunction

    function automatic cfg_t rand_rates();
        cfg_t c;
        c.rate_adp  = rand_rate();
        c.rate_mem  = rand_rate();
        c.rate_coop = rand_rate();
        c.rate_eb   = rand_rate();
        c.rate_der  = rand_rate();
        c.diff      = rand_rate();
        c.inv_vol   = rand_rate();
        return c;
    endfunction

    // Mostly the kinds that emit diffusion, some reactions-only and unused codes
    function automatic item_t rand_point();
        logic [KIND_W-1:0] kind;
        logic [CNT_W-1:0]  mem;
        kind = ($urandom_range(0, 3) == 0) ? KIND_W'($urandom_range(0, 7))
                                           : KIND_W'($urandom_range(0, 4));
        mem  = ($urandom_range(0, 3) == 0) ? '0 : rand_count();
        return make_pt(kind, POS_W'($urandom), POS_W'($urandom), POS_W'($urandom),
                       rand_count(), rand_count(), rand_count(), rand_count(),
                       rand_count(), mem, MASK_W'($urandom));
    endfunction

    // Hold until every point is sent and every result has come, then settle
    task automatic drain_all();
        while (pending_points.size() != 0 || s_tvalid || pending_props.size() != 0)
            @(posedge aclk);
        repeat (CFG_SETTLE) @(posedge aclk);
    endtask

    task automatic program_rates(input cfg_t c);
        reg_writes.push_back(reg_write_t'{CFG_RATE_ADP,  c.rate_adp});
        reg_writes.push_back(reg_write_t'{CFG_RATE_MEM,  c.rate_mem});
        reg_writes.push_back(reg_write_t'{CFG_RATE_COOP, c.rate_coop});
        reg_writes.push_back(reg_write_t'{CFG_RATE_EB,   c.rate_eb});
        reg_writes.push_back(reg_write_t'{CFG_RATE_DER,  c.rate_der});
        reg_writes.push_back(reg_write_t'{CFG_DIFF,      c.diff});
        reg_writes.push_back(reg_write_t'{CFG_INV_VOL,   c.inv_vol});
        while (reg_writes.size() != 0 || cfg_valid)
            @(posedge aclk);
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Registers still at their reset value
        pending_points.push_back(make_pt(KIND_INIT, 1, 2, 3, 100, 200, 300, 400, 500,
                                         16'h0100, 6'h3F));
        pending_points.push_back(make_pt(KIND_ALL, 5, 6, 7, '1, '1, '1, '1, '1, '1, 6'h3F));
        drain_all();

        // Moderate rates; a write to the unused index must change nothing
        reg_writes.push_back(reg_write_t'{CFG_UNUSED, 32'hDEAD_BEEF});
        program_rates(cfg_t'{32'h0002_8000, 32'h0000_4000, 32'h0001_0000, 32'h0000_0100,
                             32'h0003_0000, 32'h0000_8000, 32'h0000_2000});
        pending_points.push_back(make_pt(KIND_INIT, 0, 0, 0, 10, 20, 30, 40, 50,
                                         16'h0180, 6'h3F));
        pending_points.push_back(make_pt(KIND_INIT, 63, 63, 63, 10, 20, 30, 40, 50,
                                         16'h0000, 6'h3F));
        pending_points.push_back(make_pt(KIND_ALL, 12, 34, 56, 1000, 2000, 3000, 4000, 5000,
                                         16'h0001, 6'h3F));
        pending_points.push_back(make_pt(KIND_ALL, 7, 8, 9, 1, 2, 3, 4, 5, 16'h0000, 6'h00));
        pending_points.push_back(make_pt(KIND_ADP, 21, 42, 63, 300, 0, 0, 0, 0,
                                         16'hFFFF, 6'h2A));
        pending_points.push_back(make_pt(KIND_ATP, 42, 21, 0, 0, 300, 0, 0, 0,
                                         16'h8000, 6'h15));
        pending_points.push_back(make_pt(KIND_E, 1, 1, 1, 0, 0, 300, 7, 9, 16'h0080, 6'h3F));
        pending_points.push_back(make_pt(KIND_RXN, 3, 3, 3, 11, 22, 33, 44, 55,
                                         16'h0200, 6'h3F));
        pending_points.push_back(make_pt(KIND_SPARE_LO, 60, 0, 5, 11, 22, 33, 44, 55,
                                         16'h0200, 6'h3F));
        pending_points.push_back(make_pt(KIND_SPARE_HI, 0, 60, 5, 11, 22, 33, 44, 55,
                                         16'h0000, 6'h3F));
        pending_points.push_back(make_pt(KIND_ALL, 63, 63, 63, '1, '1, '1, '1, '1, '1, 6'h3F));
        pending_points.push_back(make_pt(KIND_INIT, 0, 0, 0, 0, 0, 0, 0, 0, 0, 6'h00));
        pending_points.push_back(make_pt(KIND_ADP, 9, 9, 9, 77, 88, 99, 1, 2, 0, 6'h01));
        pending_points.push_back(make_pt(KIND_ATP, 9, 9, 9, 77, 88, 99, 1, 2, 0, 6'h20));
        pending_points.push_back(make_pt(KIND_E, 9, 9, 9, 77, 88, 99, 1, 2, 0, 6'h10));
        drain_all();

        // All rates at full scale: saturation of the membrane products
        program_rates('1);
        pending_points.push_back(make_pt(KIND_ALL, 33, 17, 48, '1, '1, '1, '1, '1, '1, 6'h3F));
        pending_points.push_back(make_pt(KIND_INIT, 2, 4, 8, '1, '1, '1, '1, '1, 16'h0001,
                                         6'h3F));
        pending_points.push_back(make_pt(KIND_ATP, 16, 32, 62, 0, '1, 0, 0, 0, '1, 6'h0C));
        pending_points.push_back(make_pt(KIND_E, 31, 15, 7, 0, 0, '1, '1, 0, 16'h0001, 6'h03));
        drain_all();

        // Random phases, each under fresh rates, with and without idling
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            program_rates(rand_rates());
            send_steady = (ph == 1) || (ph == 3);
            recv_steady = (ph == 2) || (ph == 3);
            for (int n = 0; n < RAND_PER_PH; n++)
                pending_points.push_back(rand_point());
            drain_all();
        end

        repeat (TAIL_CYCLES) @(posedge aclk);
        if (err_cnt == 0 && pending_props.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
